### rtl/core/stmsc_pkg.sv
// ----------------------------------------------------------------------------
// stmsc_pkg: shared types and constants
// Field widths, register indexes and reset values for the servo speed control.
// ----------------------------------------------------------------------------
package stmsc_pkg;

	localparam int ADC_BITS        = 10;
	localparam int SPEED_BITS      = 8;
	localparam int ADC_MAX         = (1 << ADC_BITS) - 1;
	localparam int MAX_SAMPLES_DEF = 16;
	localparam int MIN_COUNT       = 3;
	localparam int CNT_REG_W       = 5;
	localparam int CFG_IDX_W       = 4;
	localparam int CFG_DATA_W      = 8;
	localparam int QUEUE_DEPTH     = 2;

	typedef logic [ADC_BITS-1:0]   adc_t;
	typedef logic [SPEED_BITS-1:0] speed_t;
	typedef logic [CNT_REG_W-1:0]  count_reg_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	localparam cfg_idx_t REG_SAMPLE_COUNT = cfg_idx_t'(0);
	localparam cfg_idx_t REG_DEADBAND     = cfg_idx_t'(1);

	localparam count_reg_t SAMPLE_COUNT_RST = count_reg_t'(10);
	localparam speed_t     DEADBAND_RST     = speed_t'(10);

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

### rtl/core/stmsc_ifs.sv
// ----------------------------------------------------------------------------
// stmsc channel interfaces
// Sample input, result output and register write channels, valid/ready.
// ----------------------------------------------------------------------------
interface stmsc_in_if;
	import stmsc_pkg::*;
	logic valid;
	logic ready;
	adc_t feedback_sample;
	adc_t target_position;
	modport source(output valid, output feedback_sample, output target_position, input ready);
	modport sink(input valid, input feedback_sample, input target_position, output ready);
endinterface

interface stmsc_out_if;
	import stmsc_pkg::*;
	logic   valid;
	logic   ready;
	adc_t   measured_position;
	speed_t drive_speed;
	logic   drive_forward;
	logic   at_target;
	modport source(output valid, output measured_position, output drive_speed,
		output drive_forward, output at_target, input ready);
	modport sink(input valid, input measured_position, input drive_speed,
		input drive_forward, input at_target, output ready);
endinterface

interface stmsc_cfg_if;
	import stmsc_pkg::*;
	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

### rtl/core/stmsc_front.sv
// ----------------------------------------------------------------------------
// stmsc_front: sample accumulator
// Sums samples, tracks min and max, and pushes a job when a measurement closes.
// ----------------------------------------------------------------------------
module stmsc_front #(
	parameter int MAX_SAMPLES = stmsc_pkg::MAX_SAMPLES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	stmsc_in_if.sink                 sample_in,
	input  stmsc_pkg::count_reg_t    sample_count,
	input  stmsc_pkg::qstat_t        qstat,
	output logic                     push,
	output logic [$clog2(MAX_SAMPLES*stmsc_pkg::ADC_MAX+1)+3*stmsc_pkg::ADC_BITS
		+$clog2(MAX_SAMPLES+1)-1:0] job
);
	import stmsc_pkg::*;

	localparam int CW   = $clog2(MAX_SAMPLES + 1);
	localparam int SW   = $clog2(MAX_SAMPLES * ADC_MAX + 1);
	localparam int CMPW = (CW > CNT_REG_W) ? CW : CNT_REG_W;

	logic [CW-1:0] taken_q, taken_nx;
	logic [SW-1:0] sum_q, sum_nx;
	adc_t          min_q, min_nx, max_q, max_nx;
	logic          accept, done;

	assign sample_in.ready = !qstat.full;
	assign accept = sample_in.valid && sample_in.ready;

	assign taken_nx = taken_q + CW'(1);
	assign sum_nx   = sum_q + SW'(sample_in.feedback_sample);
	assign min_nx   = (sample_in.feedback_sample < min_q) ? sample_in.feedback_sample : min_q;
	assign max_nx   = (sample_in.feedback_sample > max_q) ? sample_in.feedback_sample : max_q;

	// count clamped to [3, MAX_SAMPLES]; a count lowered mid-measurement closes on next sample
	assign done = (taken_nx >= CW'(MIN_COUNT)) &&
		((CMPW'(taken_nx) >= CMPW'(sample_count)) || (taken_nx == CW'(MAX_SAMPLES)));

	assign push = accept && done;
	assign job  = {sum_nx, min_nx, max_nx, taken_nx, sample_in.target_position};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= '0;
			sum_q   <= '0;
			min_q   <= adc_t'(ADC_MAX);
			max_q   <= '0;
		end else if (accept) begin
			if (done) begin
				taken_q <= '0;
				sum_q   <= '0;
				min_q   <= adc_t'(ADC_MAX);
				max_q   <= '0;
			end else begin
				taken_q <= taken_nx;
				sum_q   <= sum_nx;
				min_q   <= min_nx;
				max_q   <= max_nx;
			end
		end
	end

endmodule

### rtl/core/stmsc_queue.sv
// ----------------------------------------------------------------------------
// stmsc_queue: job queue
// Small register FIFO between the accumulator and the compute engine.
// ----------------------------------------------------------------------------
module stmsc_queue #(
	parameter int WIDTH = 1,
	parameter int DEPTH = stmsc_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [WIDTH-1:0]  push_data,
	input  logic              pop,
	output logic [WIDTH-1:0]  pop_data,
	output stmsc_pkg::qstat_t qstat
);
	import stmsc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [NW-1:0]    fill_q;

	assign qstat.full  = (fill_q == NW'(DEPTH));
	assign qstat.empty = (fill_q == '0);
	assign pop_data    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + NW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - NW'(1);
			end
		end
	end

endmodule

### rtl/core/stmsc_back.sv
// ----------------------------------------------------------------------------
// stmsc_back: measurement engine
// Trimmed-mean division, error scaling, deadband and the result register.
// ----------------------------------------------------------------------------
module stmsc_back #(
	parameter int MAX_SAMPLES = stmsc_pkg::MAX_SAMPLES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [$clog2(MAX_SAMPLES*stmsc_pkg::ADC_MAX+1)+3*stmsc_pkg::ADC_BITS
		+$clog2(MAX_SAMPLES+1)-1:0] job,
	input  stmsc_pkg::qstat_t     qstat,
	output logic                  pop,
	input  stmsc_pkg::speed_t     deadband_speed,
	stmsc_out_if.source           result_out
);
	import stmsc_pkg::*;

	localparam int CW   = $clog2(MAX_SAMPLES + 1);
	localparam int SW   = $clog2(MAX_SAMPLES * ADC_MAX + 1);
	localparam int ITW  = $clog2(ADC_BITS);
	localparam int PRW  = ADC_BITS + SPEED_BITS;

	typedef enum logic [2:0] {IDLE, DIV, ERR, MUL, FIN} state_t;

	state_t          state_q;
	logic [CW-1:0]   div_q, rem_q;
	adc_t            quo_q, target_q, err_q;
	logic [ITW-1:0]  cnt_q;
	logic            fwd_q, hit_q;
	logic [PRW-1:0]  prod_q;
	logic            ov_q;
	adc_t            mpos_q;
	speed_t          speed_q;
	logic            dfwd_q, hit_out_q;

	// job fields
	logic [SW-1:0]   j_sum;
	adc_t            j_min, j_max, j_target;
	logic [CW-1:0]   j_taken;
	logic [SW-1:0]   num;

	// divider step
	logic [CW+1:0]   diff;

	// speed path
	adc_t            scaled;
	speed_t          q0, spd, spd_db;
	logic [ADC_BITS:0] rsum;
	logic            load_out;

	assign {j_sum, j_min, j_max, j_taken, j_target} = job;
	assign num = j_sum - SW'(j_min) - SW'(j_max);
	assign pop = (state_q == IDLE) && !qstat.empty;

	// restoring division, one quotient bit per cycle; quotient shifts into quo_q
	assign diff = {1'b0, rem_q, quo_q[ADC_BITS-1]} - {2'b00, div_q};

	// saturate 2*err at full scale
	assign scaled = err_q[ADC_BITS-1] ? adc_t'(ADC_MAX) : {err_q[ADC_BITS-2:0], 1'b0};

	// prod / 1023: estimate by >>10, remainder stays below 2*1023, one correction
	assign q0     = prod_q[PRW-1:ADC_BITS];
	assign rsum   = {1'b0, prod_q[ADC_BITS-1:0]} + (ADC_BITS+1)'(q0);
	assign spd    = q0 + speed_t'(rsum >= (ADC_BITS+1)'(ADC_MAX));
	assign spd_db = (spd < deadband_speed) ? '0 : spd;

	assign load_out = (state_q == FIN) && (!ov_q || result_out.ready);

	assign result_out.valid             = ov_q;
	assign result_out.measured_position = mpos_q;
	assign result_out.drive_speed       = speed_q;
	assign result_out.drive_forward     = dfwd_q;
	assign result_out.at_target         = hit_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			ov_q      <= 1'b0;
			div_q     <= '0;
			rem_q     <= '0;
			quo_q     <= '0;
			target_q  <= '0;
			err_q     <= '0;
			cnt_q     <= '0;
			fwd_q     <= 1'b0;
			hit_q     <= 1'b0;
			prod_q    <= '0;
			mpos_q    <= '0;
			speed_q   <= '0;
			dfwd_q    <= 1'b0;
			hit_out_q <= 1'b0;
		end else begin
			// result register: a new load wins over the drain of the old one
			if (load_out) begin
				ov_q <= 1'b1;
			end else if (ov_q && result_out.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (pop) begin
						rem_q    <= CW'(num >> ADC_BITS);
						quo_q    <= num[ADC_BITS-1:0];
						div_q    <= j_taken - CW'(2);
						target_q <= j_target;
						cnt_q    <= '0;
						state_q  <= DIV;
					end
				end
				DIV: begin
					if (!diff[CW+1]) begin
						rem_q <= diff[CW-1:0];
						quo_q <= {quo_q[ADC_BITS-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[CW-2:0], quo_q[ADC_BITS-1]};
						quo_q <= {quo_q[ADC_BITS-2:0], 1'b0};
					end
					cnt_q <= cnt_q + ITW'(1);
					if (cnt_q == ITW'(ADC_BITS - 1)) begin
						state_q <= ERR;
					end
				end
				ERR: begin
					hit_q   <= (quo_q == target_q);
					fwd_q   <= (quo_q > target_q);
					err_q   <= (quo_q > target_q) ? quo_q - target_q : target_q - quo_q;
					state_q <= MUL;
				end
				MUL: begin
					// x*255 as x*256 - x
					prod_q  <= {scaled, {SPEED_BITS{1'b0}}} - PRW'(scaled);
					state_q <= FIN;
				end
				FIN: begin
					if (load_out) begin
						mpos_q    <= quo_q;
						speed_q   <= hit_q ? '0 : spd_db;
						dfwd_q    <= fwd_q;
						hit_out_q <= hit_q;
						state_q   <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

### rtl/core/servo_trimmed_mean_speed_control.sv
// ----------------------------------------------------------------------------
// servo_trimmed_mean_speed_control: servo position measurement and drive
// Trimmed-mean position from ADC samples, proportional speed with deadband.
// ----------------------------------------------------------------------------
// Usage:
//  sample_in   one feedback ADC reading plus target per transfer. Accepted in
//              every cycle while the job queue has room.
//  result_out  one transfer per measurement (every sample_count samples,
//              clamped to 3..MAX_SAMPLES): trimmed mean, speed, direction and
//              at_target.
//  cfg         register writes, always ready; index 0 sample_count, index 1
//              deadband_speed. Write only while the block is idle.
// Sequence: the closing sample enters the queue at once; the engine then loads
//  the job, runs the bit-serial divider for ADC_BITS (10) quotient bits, forms
//  the error and the scaled product, and fills the result register, which
//  raises result valid.
// The engine pops no new job before the last one has reached the result register.
//  With the 2-entry queue the front keeps taking samples while the engine works.
// Reset clears the accumulation, empties the queue and loads both registers
//  with 10. A stalled receiver holds the result register; the engine then
//  waits, the queue fills, and sample_in drops ready.
// ----------------------------------------------------------------------------
module servo_trimmed_mean_speed_control #(
	parameter int MAX_SAMPLES = stmsc_pkg::MAX_SAMPLES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	stmsc_in_if.sink     sample_in,
	stmsc_out_if.source  result_out,
	stmsc_cfg_if.sink    cfg
);
	import stmsc_pkg::*;

	localparam int CW    = $clog2(MAX_SAMPLES + 1);
	localparam int SW    = $clog2(MAX_SAMPLES * ADC_MAX + 1);
	localparam int JOB_W = SW + 3 * ADC_BITS + CW;

	// configuration registers
	count_reg_t sample_count_q;
	speed_t     deadband_q;

	// front/back hand-off
	logic             push, pop;
	logic [JOB_W-1:0] push_job, pop_job;
	qstat_t           qstat;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= SAMPLE_COUNT_RST;
			deadband_q     <= DEADBAND_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SAMPLE_COUNT: sample_count_q <= cfg.data[CNT_REG_W-1:0];
				REG_DEADBAND:     deadband_q     <= cfg.data[SPEED_BITS-1:0];
				default:          ; // unmapped index: write dropped
			endcase
		end
	end

	// front: accumulate samples, close a measurement into one job
	stmsc_front #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_in   (sample_in),
		.sample_count(sample_count_q),
		.qstat       (qstat),
		.push        (push),
		.job         (push_job)
	);

	// decouples sample intake from the multi-cycle engine
	stmsc_queue #(
		.WIDTH(JOB_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_job),
		.pop      (pop),
		.pop_data (pop_job),
		.qstat    (qstat)
	);

	// back: divide, scale, deadband, hold result until transfer
	stmsc_back #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job           (pop_job),
		.qstat         (qstat),
		.pop           (pop),
		.deadband_speed(deadband_q),
		.result_out    (result_out)
	);

endmodule
